@@ src/assert_macros.svh @@
// Shared concurrent assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AST_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked also during reset.
`define AST_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/rotm_pkg.sv @@
package rotm_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int SAMPLE_WIDTH = 16;

    localparam int ANGLE_W  = 16;
    localparam int OP_W     = 2;
    localparam int ELEM_W   = 16;
    localparam int FRAC     = SAMPLE_WIDTH - 2;
    // one guard bit above the sample word
    localparam int XW       = SAMPLE_WIDTH + 1;
    localparam int ZW       = 32;
    localparam int ZEXT_W   = 34;
    localparam int ATAN_IDX_W = 5;

    localparam logic [OP_W-1:0] AXIS_X = 2'd0;
    localparam logic [OP_W-1:0] AXIS_Y = 2'd1;
    localparam logic [OP_W-1:0] AXIS_Z = 2'd2;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint ONE_Q14     = 64'sd16384;

    localparam longint GAIN_X0 = (FRAC < 30)
        ? ((GAIN_Q30 + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC)) : GAIN_Q30;

    // conversion of the CORDIC word to Q1.14
    localparam int     RND_SH   = (FRAC > 14) ? (FRAC - 14) : 0;
    localparam int     LSH      = (FRAC < 14) ? (14 - FRAC) : 0;
    localparam longint RND_HALF = (RND_SH > 0) ? (64'sd1 <<< (RND_SH - 1)) : 64'sd0;
    localparam int     WW       = XW + LSH + 1;

    typedef struct packed {
        logic                  valid;
        logic [OP_W-1:0]       op;
        logic                  flip;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
    } mat_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic [ZW-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ src/rotm_prep.sv @@
module rotm_prep
    import rotm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [OP_W-1:0]           in_op,
    input  logic signed [ANGLE_W-1:0] in_angle,
    output cordic_t                   out_stage
);

    cordic_t                   stage_reg;
    cordic_t                   stage_next;
    logic signed [ZEXT_W-1:0]  z_raw;
    logic signed [ZEXT_W-1:0]  z_red;

    always_comb begin
        z_raw = ZEXT_W'(in_angle) <<< 17;
        stage_next.flip = 1'b0;
        z_red = z_raw;
        // fold into the right half plane, negate the result later
        if (z_raw > ZEXT_W'(HALF_PI_Q30)) begin
            z_red = z_raw - ZEXT_W'(PI_Q30);
            stage_next.flip = 1'b1;
        end else if (z_raw < -ZEXT_W'(HALF_PI_Q30)) begin
            z_red = z_raw + ZEXT_W'(PI_Q30);
            stage_next.flip = 1'b1;
        end
        stage_next.valid = in_valid;
        stage_next.op    = in_op;
        stage_next.x     = XW'(GAIN_X0);
        stage_next.y     = '0;
        stage_next.z     = z_red[ZW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

@@ src/rotm_cell.sv @@
module rotm_cell
    import rotm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic [ATAN_IDX_W-1:0] step,
    input  cordic_t               in_stage,
    output cordic_t               out_stage
);

    cordic_t              stage_reg;
    cordic_t              stage_next;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic [ZW-1:0]        ang;

    always_comb begin
        dx  = in_stage.y >>> step;
        dy  = in_stage.x >>> step;
        ang = atan_q30(step);
        stage_next = in_stage;
        if (!in_stage.z[ZW-1]) begin
            stage_next.x = in_stage.x - dx;
            stage_next.y = in_stage.y + dy;
            stage_next.z = in_stage.z - $signed(ang);
        end else begin
            stage_next.x = in_stage.x + dx;
            stage_next.y = in_stage.y - dy;
            stage_next.z = in_stage.z + $signed(ang);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign out_stage = stage_reg;

endmodule

@@ src/rotm_post.sv @@
module rotm_post
    import rotm_pkg::*;
(
    input  cordic_t in_stage,
    output mat_t    out_mat
);

    localparam logic signed [ELEM_W-1:0] ONE = ELEM_W'(ONE_Q14);

    logic signed [XW-1:0]     xf;
    logic signed [XW-1:0]     yf;
    logic signed [ELEM_W-1:0] c;
    logic signed [ELEM_W-1:0] s;
    logic signed [ELEM_W-1:0] ns;

    function automatic logic signed [ELEM_W-1:0] to_q14(input logic signed [XW-1:0] v);
        logic signed [WW-1:0] w;
        w = WW'(v);
        w = (w + WW'(RND_HALF)) >>> RND_SH;
        w = w <<< LSH;
        if (w > WW'(ONE_Q14)) begin
            w = WW'(ONE_Q14);
        end else if (w < -WW'(ONE_Q14)) begin
            w = -WW'(ONE_Q14);
        end
        return w[ELEM_W-1:0];
    endfunction

    always_comb begin
        xf = in_stage.flip ? -in_stage.x : in_stage.x;
        yf = in_stage.flip ? -in_stage.y : in_stage.y;
        c  = to_q14(xf);
        s  = to_q14(yf);
        ns = -s;
        out_mat = '0;
        unique case (in_stage.op)
            AXIS_X: begin
                out_mat.m00 = ONE;
                out_mat.m11 = c;
                out_mat.m12 = ns;
                out_mat.m21 = s;
                out_mat.m22 = c;
            end
            AXIS_Y: begin
                out_mat.m00 = c;
                out_mat.m02 = s;
                out_mat.m11 = ONE;
                out_mat.m20 = ns;
                out_mat.m22 = c;
            end
            AXIS_Z: begin
                out_mat.m00 = c;
                out_mat.m01 = ns;
                out_mat.m10 = s;
                out_mat.m11 = c;
                out_mat.m22 = ONE;
            end
            default: begin
                out_mat.m00 = ONE;
                out_mat.m11 = ONE;
                out_mat.m22 = ONE;
            end
        endcase
    end

endmodule

@@ src/rotm_obuf.sv @@
`include "assert_macros.svh"

module rotm_obuf
    import rotm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  mat_t in_mat,
    output logic in_ready,
    output logic m_valid,
    input  logic m_ready,
    output mat_t out_mat
);

    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    mat_t out_data_reg;
    mat_t out_data_next;
    mat_t skid_data_reg;
    mat_t skid_data_next;
    logic push;
    logic pop;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign pop      = out_valid_reg && m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop || !out_valid_reg) begin
            // refill the output from the skid first
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_data_next  = in_mat;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_mat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign out_mat = out_data_reg;

    `AST_IMPL(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `AST_NEXT(a_skid_drains, aclk, aresetn && skid_valid_reg && m_ready, !skid_valid_reg)

endmodule

@@ src/axis_rotation_matrix_generator_core.sv @@
// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_operation[1:0], s_angle[15:0] (Q2.13)
// m_        m_valid / m_ready    m_m00 .. m_m22, 16 bits each (Q1.14)
//
// One beat in per cycle while s_ready is high; each beat passes through
// one angle-folding stage, one cell per CORDIC step and one output register.
// The output register plus a one-entry skid let s_ready come from a flop.
// While the skid holds a beat, s_ready is low and the whole cell row holds.
// Reset (aresetn low, synchronous) clears every valid bit; data flops keep.
`include "assert_macros.svh"

module axis_rotation_matrix_generator_core
    import rotm_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_operation,
    input  logic signed [ANGLE_W-1:0] s_angle,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ELEM_W-1:0]  m_m00,
    output logic signed [ELEM_W-1:0]  m_m01,
    output logic signed [ELEM_W-1:0]  m_m02,
    output logic signed [ELEM_W-1:0]  m_m10,
    output logic signed [ELEM_W-1:0]  m_m11,
    output logic signed [ELEM_W-1:0]  m_m12,
    output logic signed [ELEM_W-1:0]  m_m20,
    output logic signed [ELEM_W-1:0]  m_m21,
    output logic signed [ELEM_W-1:0]  m_m22
);

    cordic_t stage [0:CORDIC_STEPS];
    mat_t    fin_mat;
    mat_t    out_mat;
    logic    en;

    rotm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_op     (s_operation),
        .in_angle  (s_angle),
        .out_stage (stage[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
        rotm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step      (ATAN_IDX_W'(i)),
            .in_stage  (stage[i]),
            .out_stage (stage[i+1])
        );
    end

    rotm_post u_post (
        .in_stage (stage[CORDIC_STEPS]),
        .out_mat  (fin_mat)
    );

    rotm_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stage[CORDIC_STEPS].valid),
        .in_mat   (fin_mat),
        .in_ready (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_mat  (out_mat)
    );

    assign s_ready = en;
    assign m_m00   = out_mat.m00;
    assign m_m01   = out_mat.m01;
    assign m_m02   = out_mat.m02;
    assign m_m10   = out_mat.m10;
    assign m_m11   = out_mat.m11;
    assign m_m12   = out_mat.m12;
    assign m_m20   = out_mat.m20;
    assign m_m21   = out_mat.m21;
    assign m_m22   = out_mat.m22;

    `AST_NEXT(a_reset_empties, aclk, !aresetn, !m_valid)
    `AST_NEXT(a_accept_enters, aclk, aresetn && s_valid && s_ready, stage[0].valid)
    `AST_IMPL(a_stall_means_full, aclk, aresetn, !s_ready, m_valid)

endmodule

@@ tb/tb_axis_rotation_matrix_generator_core.sv @@
module tb_axis_rotation_matrix_generator_core
    import rotm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] AXIS_NONE = 2'd3;
    localparam int RANDOM_BEATS = 450;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = CORDIC_STEPS + 8;
    localparam int N_DIRECTED   = 20;

    localparam longint ATAN_STEPS [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };

    localparam mat_t IDENTITY = '{16'sd16384, 16'sd0, 16'sd0,
                                  16'sd0, 16'sd16384, 16'sd0,
                                  16'sd0, 16'sd0, 16'sd16384};

    typedef struct {
        logic [OP_W-1:0]           op;
        logic signed [ANGLE_W-1:0] ang;
        bit                        typed;
        mat_t                      want;
    } stim_row_t;

    // typed rows carry a matrix readable at a glance; the rest use the predictor
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{AXIS_X, 16'sd0, 1'b0, '0},
        '{AXIS_Y, 16'sd0, 1'b0, '0},
        '{AXIS_Z, 16'sd0, 1'b0, '0},
        '{AXIS_X, 16'sd25736, 1'b0, '0},
        '{AXIS_Y, -16'sd25736, 1'b0, '0},
        '{AXIS_Z, 16'sd25736, 1'b0, '0},
        '{AXIS_Z, -16'sd25736, 1'b0, '0},
        '{AXIS_X, 16'sd12867, 1'b0, '0},
        '{AXIS_Y, 16'sd12868, 1'b0, '0},
        '{AXIS_Z, -16'sd12867, 1'b0, '0},
        '{AXIS_Z, -16'sd12868, 1'b0, '0},
        '{AXIS_X, 16'sd32767, 1'b0, '0},
        '{AXIS_Y, -16'sd32768, 1'b0, '0},
        '{AXIS_Z, 16'sd1, 1'b0, '0},
        '{AXIS_X, -16'sd1, 1'b0, '0},
        '{AXIS_Y, 16'sd6434, 1'b0, '0},
        '{AXIS_NONE, 16'sd0, 1'b1, IDENTITY},
        '{AXIS_NONE, 16'sd32767, 1'b1, IDENTITY},
        '{AXIS_NONE, -16'sd32768, 1'b1, IDENTITY},
        '{AXIS_Z, -16'sd6434, 1'b0, '0}
    };

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [OP_W-1:0]           s_operation;
    logic signed [ANGLE_W-1:0] s_angle;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [ELEM_W-1:0]  m_m00, m_m01, m_m02;
    logic signed [ELEM_W-1:0]  m_m10, m_m11, m_m12;
    logic signed [ELEM_W-1:0]  m_m20, m_m21, m_m22;

    mat_t expected_mats [$];
    int   errors = 0;
    int   beats_sent = 0;
    int   mats_seen = 0;

    axis_rotation_matrix_generator_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_angle     (s_angle),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_m00       (m_m00),
        .m_m01       (m_m01),
        .m_m02       (m_m02),
        .m_m10       (m_m10),
        .m_m11       (m_m11),
        .m_m12       (m_m12),
        .m_m20       (m_m20),
        .m_m21       (m_m21),
        .m_m22       (m_m22)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint to_q14(input longint v);
        longint r;
        if (FRAC > 14) begin
            r = (v + (64'sd1 << (FRAC - 15))) >>> (FRAC - 14);
        end else begin
            r = v * (64'sd1 << (14 - FRAC));
        end
        if (r > ONE_Q14) r = ONE_Q14;
        if (r < -ONE_Q14) r = -ONE_Q14;
        return r;
    endfunction

    // fold the angle into +-pi/2, run the CORDIC, then undo the fold
    function automatic void cordic_sin_cos(input logic signed [ANGLE_W-1:0] ang,
                                           output longint c, output longint s);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'(ang) * 131072;
        flip = 1'b0;
        if (z > HALF_PI_Q30) begin
            z = z - PI_Q30;
            flip = 1'b1;
        end else if (z < -HALF_PI_Q30) begin
            z = z + PI_Q30;
            flip = 1'b1;
        end
        if (FRAC < 30) begin
            x = (GAIN_Q30 + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
        end else begin
            x = GAIN_Q30;
        end
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEPS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEPS[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = to_q14(x);
        s = to_q14(y);
    endfunction

    function automatic mat_t rotation_matrix(input logic [OP_W-1:0] op,
                                             input logic signed [ANGLE_W-1:0] ang);
        longint c, s;
        logic signed [ELEM_W-1:0] ce, se, ne;
        mat_t m;
        cordic_sin_cos(ang, c, s);
        ce = ELEM_W'(c);
        se = ELEM_W'(s);
        ne = ELEM_W'(-s);
        m = '0;
        unique case (op)
            AXIS_X: begin
                m.m00 = 16'sd16384;
                m.m11 = ce; m.m12 = ne;
                m.m21 = se; m.m22 = ce;
            end
            AXIS_Y: begin
                m.m00 = ce; m.m02 = se;
                m.m11 = 16'sd16384;
                m.m20 = ne; m.m22 = ce;
            end
            AXIS_Z: begin
                m.m00 = ce; m.m01 = ne;
                m.m10 = se; m.m11 = ce;
                m.m22 = 16'sd16384;
            end
            default: m = IDENTITY;
        endcase
        return m;
    endfunction

    task automatic check_elem(input string name, input logic signed [ELEM_W-1:0] want,
                              input logic signed [ELEM_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // offer one beat after a random gap; the gap is skipped in the burst window
    task automatic send_angle(input logic [OP_W-1:0] op, input logic signed [ANGLE_W-1:0] ang,
                              input bit typed, input mat_t want);
        int gap;
        gap = (beats_sent >= 150 && beats_sent < 220) ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_operation = op;
        s_angle = ang;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_mats.push_back(typed ? want : rotation_matrix(op, ang));
        beats_sent++;
        @(negedge aclk);
    endtask

    function automatic logic signed [ANGLE_W-1:0] draw_angle();
        int kind;
        int base;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            return ANGLE_W'(int'($urandom_range(0, 51472)) - 25736);
        end else if (kind == 7) begin
            return ANGLE_W'($urandom);
        end
        case ($urandom_range(0, 6))
            0: base = 0;
            1: base = 12868;
            2: base = -12868;
            3: base = 25736;
            4: base = -25736;
            5: base = 32767;
            default: base = -32768;
        endcase
        return ANGLE_W'(base + int'($urandom_range(0, 6)) - 3);
    endfunction

    // result side: random stall per beat, none in a fast window, one long hold to back up the pipeline
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (mats_seen == 60) begin
                stall = LONG_HOLD;
            end else if (mats_seen >= 300 && mats_seen < 370) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 5);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            mats_seen++;
            if (expected_mats.size() == 0) begin
                $error("result beat with no matrix expected");
                errors++;
            end else begin
                mat_t want;
                want = expected_mats.pop_front();
                check_elem("m00", want.m00, m_m00);
                check_elem("m01", want.m01, m_m01);
                check_elem("m02", want.m02, m_m02);
                check_elem("m10", want.m10, m_m10);
                check_elem("m11", want.m11, m_m11);
                check_elem("m12", want.m12, m_m12);
                check_elem("m20", want.m20, m_m20);
                check_elem("m21", want.m21, m_m21);
                check_elem("m22", want.m22, m_m22);
            end
            @(negedge aclk);
        end
    end

    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        logic [OP_W-1:0] op;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = '0;
        s_angle = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_angle(directed_rows[i].op, directed_rows[i].ang,
                       directed_rows[i].typed, directed_rows[i].want);
        end

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            op = ($urandom_range(0, 9) == 0) ? AXIS_NONE : OP_W'($urandom_range(0, 2));
            send_angle(op, draw_angle(), 1'b0, '0);
        end
        s_valid = 1'b0;

        while (expected_mats.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ axis_rotation_matrix_generator_core.f @@
+incdir+src
src/rotm_pkg.sv
src/rotm_prep.sv
src/rotm_cell.sv
src/rotm_post.sv
src/rotm_obuf.sv
src/axis_rotation_matrix_generator_core.sv
tb/tb_axis_rotation_matrix_generator_core.sv
